// File: rtl/core/sffp_pkg.sv
package sffp_pkg;

    localparam int unsigned NUM_FIELDS = 8;
    localparam int unsigned FIELD_W    = 32;
    localparam int unsigned HELD_IDX_W = 3;

    localparam logic [7:0] START_BYTE_A = 8'h0b;
    localparam logic [7:0] START_BYTE_B = 8'h0a;
    localparam logic [7:0] FIELD_SEP    = 8'h2c;

    typedef logic [FIELD_W-1:0] field_t;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_GOT_A  = 4'd1,
        PH_FIELD0 = 4'd2,
        PH_FIELD1 = 4'd3,
        PH_FIELD2 = 4'd4,
        PH_FIELD3 = 4'd5,
        PH_FIELD4 = 4'd6,
        PH_FIELD5 = 4'd7,
        PH_FIELD6 = 4'd8,
        PH_FIELD7 = 4'd9
    } phase_t;

    // Multiply by ten and add the raw byte, wrapping at the field width.
    function automatic field_t acc_step(input field_t acc, input logic [7:0] data);
        acc_step = {acc[FIELD_W-4:0], 3'b000} + {acc[FIELD_W-2:0], 1'b0}
                 + {{(FIELD_W-8){1'b0}}, data};
    endfunction

endpackage

// File: rtl/core/sffp_field_core.sv
module sffp_field_core
    import sffp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data,
    output logic        emit,
    output field_t      frame [NUM_FIELDS]
);

    phase_t phase_reg;
    phase_t phase_next;
    field_t acc_reg;
    field_t acc_next;
    field_t held_reg [NUM_FIELDS-1];

    logic                  held_we;
    logic [HELD_IDX_W-1:0] held_idx;

    assign held_idx = HELD_IDX_W'(4'(phase_reg) - 4'(PH_FIELD0));

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        held_we    = 1'b0;
        emit       = 1'b0;
        unique case (phase_reg)
            PH_GOT_A:
            begin
                phase_next = (data == START_BYTE_B) ? PH_FIELD0 : PH_HUNT;
            end
            PH_FIELD0, PH_FIELD1, PH_FIELD2, PH_FIELD3,
            PH_FIELD4, PH_FIELD5, PH_FIELD6:
            begin
                if (data == FIELD_SEP)
                begin
                    held_we    = 1'b1;
                    acc_next   = '0;
                    phase_next = phase_t'(4'(phase_reg) + 4'd1);
                end
                else
                begin
                    acc_next = acc_step(acc_reg, data);
                end
            end
            PH_FIELD7:
            begin
                if (data == START_BYTE_A)
                begin
                    // Closing start byte doubles as the first byte of the next pair.
                    emit       = 1'b1;
                    acc_next   = '0;
                    phase_next = PH_GOT_A;
                end
                else
                begin
                    acc_next = acc_step(acc_reg, data);
                end
            end
            default:
            begin
                acc_next   = '0;
                phase_next = (data == START_BYTE_A) ? PH_GOT_A : PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < NUM_FIELDS - 1; k++)
        begin
            frame[k] = held_reg[k];
        end
        frame[NUM_FIELDS-1] = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            acc_reg   <= '0;
            for (int k = 0; k < NUM_FIELDS - 1; k++)
            begin
                held_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            for (int k = 0; k < NUM_FIELDS - 1; k++)
            begin
                if (held_we && (held_idx == HELD_IDX_W'(k)))
                begin
                    held_reg[k] <= acc_reg;
                end
            end
        end
    end

endmodule

// File: rtl/core/sensor_frame_field_parser_unit.sv
// Sensor frame field parser. Bytes arrive one per input transaction on
// rx_byte. The parser hunts for the start pair 0x0b 0x0a, then reads eight
// fields; each field value is built as value*10 + raw byte (no ASCII offset),
// wrapping modulo 2^32. Fields one to seven end at a comma 0x2c; field eight
// ends at 0x0b, which also serves as the first start byte of the next frame.
// On that closing byte one output transaction carries all eight values. A
// wrong second start byte sends the parser back to hunting. Input takes one
// byte per cycle while no closing byte is held; each byte passes the input
// register before it reaches the parser, and a frame result is loaded into
// the output register as the parser takes its closing byte.
// A byte that closes a frame holds in the input register only while the
// previous result still waits in the output register with out_stall high;
// all other bytes keep moving regardless of the output side.
module sensor_frame_field_parser_unit
    import sffp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] ch1_average,
    output logic [31:0] ch1_value,
    output logic [31:0] ch1_power,
    output logic [31:0] ch1_strength,
    output logic [31:0] ch2_average,
    output logic [31:0] ch2_value,
    output logic [31:0] ch2_power,
    output logic [31:0] ch2_strength
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Output register
    logic   out_valid_reg;
    field_t out_reg [NUM_FIELDS];

    logic   core_emit;
    field_t core_frame [NUM_FIELDS];
    logic   advance;
    logic   in_accept;
    logic   out_accept;

    sffp_field_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .data  (in_byte_reg),
        .emit  (core_emit),
        .frame (core_frame)
    );

    // Hand the held byte to the parser unless it closes a frame and the
    // output slot is still occupied by a stalled result.
    assign out_accept = out_valid_reg && !out_stall;
    assign advance    = in_valid_reg && !(core_emit && out_valid_reg && out_stall);
    assign in_stall   = in_valid_reg && !advance;
    assign in_accept  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Refill the input register, or drain it once the byte moved on.
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            // Load a finished frame, or drop the slot once it is taken.
            if (advance && core_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && core_emit)
        begin
            out_reg <= core_frame;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ch1_average  = out_reg[0];
    assign ch1_value    = out_reg[1];
    assign ch1_power    = out_reg[2];
    assign ch1_strength = out_reg[3];
    assign ch2_average  = out_reg[4];
    assign ch2_value    = out_reg[5];
    assign ch2_power    = out_reg[6];
    assign ch2_strength = out_reg[7];

endmodule

// File: verif/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sffp_pkg::*;

    // Eight field values of one frame; index 0 is ch1_average, index 7 is ch2_strength.
    typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] frame_t;

    localparam int NUM_BYTES   = 1100;
    localparam int DRAIN_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] ch1_average;
    logic [31:0] ch1_value;
    logic [31:0] ch1_power;
    logic [31:0] ch1_strength;
    logic [31:0] ch2_average;
    logic [31:0] ch2_value;
    logic [31:0] ch2_power;
    logic [31:0] ch2_strength;

    sensor_frame_field_parser_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ch1_average  (ch1_average),
        .ch1_value    (ch1_value),
        .ch1_power    (ch1_power),
        .ch1_strength (ch1_strength),
        .ch2_average  (ch2_average),
        .ch2_value    (ch2_value),
        .ch2_power    (ch2_power),
        .ch2_strength (ch2_strength)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stream bytes waiting to go out, and frames the parser still owes us.
    logic [7:0] byte_q[$];
    frame_t     frame_q[$];

    // Parser shadow state.
    phase_t     sh_phase = PH_HUNT;
    field_t     sh_acc = '0;
    field_t     sh_held[NUM_FIELDS-1] = '{default: '0};

    int         errors = 0;
    int         bytes_taken = 0;
    int         frames_seen = 0;
    bit         chained = 1'b0;

    logic       in_fire = 1'b0;
    int         in_gap = 0;
    int         in_calm = 0;
    int         out_hold = 0;
    int         out_calm = 0;

    string field_name[NUM_FIELDS] = '{"ch1_average", "ch1_value", "ch1_power",
        "ch1_strength", "ch2_average", "ch2_value", "ch2_power", "ch2_strength"};

    // Advance the shadow parser by one byte. Return 1 and the finished frame when the
    // byte closes a frame.
    function automatic bit parse_byte(input logic [7:0] b, output frame_t done);
        bit closed;
        closed = 1'b0;
        done = '0;
        case (sh_phase)
            PH_GOT_A:
                sh_phase = (b == START_BYTE_B) ? PH_FIELD0 : PH_HUNT;
            PH_FIELD0, PH_FIELD1, PH_FIELD2, PH_FIELD3,
            PH_FIELD4, PH_FIELD5, PH_FIELD6:
                if (b == FIELD_SEP)
                begin
                    sh_held[HELD_IDX_W'(sh_phase - PH_FIELD0)] = sh_acc;
                    sh_acc = '0;
                    sh_phase = phase_t'(sh_phase + 1);
                end
                else
                    sh_acc = sh_acc * 32'd10 + {24'd0, b};
            PH_FIELD7:
                if (b == START_BYTE_A)
                begin
                    for (int k = 0; k < NUM_FIELDS - 1; k++)
                        done[k] = sh_held[k];
                    done[NUM_FIELDS-1] = sh_acc;
                    sh_acc = '0;
                    // The closing byte doubles as the first start byte.
                    sh_phase = PH_GOT_A;
                    closed = 1'b1;
                end
                else
                    sh_acc = sh_acc * 32'd10 + {24'd0, b};
            default:
            begin
                sh_acc = '0;
                sh_phase = (b == START_BYTE_A) ? PH_GOT_A : PH_HUNT;
            end
        endcase
        return closed;
    endfunction

    // Idle length for either side: mostly none or short, a few long, and now and
    // then a calm stretch with no idling at all.
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 3)
        begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Field content byte: mostly small raw values and ASCII digits, some full range.
    // The terminator of the field is kept out; the other special byte is let in on
    // purpose now and then.
    function automatic logic [7:0] content_byte(input logic [7:0] term, input logic [7:0] other);
        int r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 40)
            b = 8'($urandom_range(0, 9));
        else if (r < 65)
            b = 8'($urandom_range(8'h30, 8'h39));
        else if (r < 70)
            b = other;
        else
            b = 8'($urandom_range(0, 255));
        if (b == term)
            b = ~term;
        return b;
    endfunction

    // Append one byte to the end of the stream.
    task automatic queue_byte(input logic [7:0] b);
        byte_q = {byte_q, b};
    endtask

    // Queue one well-formed frame with random content. A frame right after another
    // one reuses its closing byte as the first start byte.
    task automatic add_frame();
        int len;
        int r;
        if (!chained)
            queue_byte(START_BYTE_A);
        queue_byte(START_BYTE_B);
        for (int f = 0; f < NUM_FIELDS; f++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(0, 3);
            else if (r < 95)
                len = $urandom_range(4, 8);
            else
                len = $urandom_range(9, 14);  // long enough to wrap the field
            for (int i = 0; i < len; i++)
                if (f < NUM_FIELDS - 1)
                    queue_byte(content_byte(FIELD_SEP, START_BYTE_A));
                else
                    queue_byte(content_byte(START_BYTE_A, FIELD_SEP));
            queue_byte((f < NUM_FIELDS - 1) ? FIELD_SEP : START_BYTE_A);
        end
        chained = 1'b1;
    endtask

    // Queue a broken or noisy stretch.
    task automatic add_noise();
        int r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            // Wrong second start byte; a repeated start byte is one of the wrong ones.
            if (!chained)
                queue_byte(START_BYTE_A);
            do
                b = ($urandom_range(0, 2) == 0) ? START_BYTE_A : 8'($urandom_range(0, 255));
            while (b == START_BYTE_B);
            queue_byte(b);
        end
        else if (r < 90)
        begin
            // Line noise while hunting, free of the first start byte 0x0b.
            if (chained)
                queue_byte(8'h00);
            repeat ($urandom_range(1, 6))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == START_BYTE_A)
                    b = 8'hff;
                queue_byte(b);
            end
        end
        else
        begin
            // Truncated frame: a few fields, then the stream moves on.
            if (!chained)
                queue_byte(START_BYTE_A);
            queue_byte(START_BYTE_B);
            repeat ($urandom_range(0, 5))
            begin
                queue_byte(content_byte(FIELD_SEP, START_BYTE_A));
                queue_byte(FIELD_SEP);
            end
        end
        chained = 1'b0;
    endtask

    // Fill the stream, then reset.
    initial
    begin
        // Directed opening: a start byte followed by another start byte, a stray
        // second start byte while hunting, then a frame with the 0xff extreme, a
        // start byte inside a field, empty fields, a zero field and a comma inside
        // field eight, then a chained frame of all empty fields.
        byte_q = '{8'h0b, 8'h0b, 8'h0a,
                   8'h0b, 8'h0a, 8'hff, 8'h2c, 8'h0b, 8'h2c, 8'h2c, 8'h2c, 8'h2c, 8'h2c,
                   8'h00, 8'h2c, 8'h2c, 8'hff, 8'h2c, 8'h0b,
                   8'h0a, 8'h2c, 8'h2c, 8'h2c, 8'h2c, 8'h2c, 8'h2c, 8'h2c, 8'h0b};
        chained = 1'b1;

        // Random part: mostly valid frames, the rest broken sequences and noise.
        while (byte_q.size() < NUM_BYTES)
            if ($urandom_range(0, 99) < 85)
                add_frame();
            else
                add_noise();

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Input driver: change at the falling edge. Hold the transaction while stalled,
    // otherwise idle for the chosen gap or advance to the next byte.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;  // hold the stalled transaction as it is
        else if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            in_gap--;
        end
        else if (byte_q.size() != 0)
        begin
            in_valid <= 1'b1;
            rx_byte <= byte_q.pop_front();
            in_gap = pick_gap(in_calm);
        end
        else
            in_valid <= 1'b0;
    end

    // Output back-pressure: stall windows of random length, also at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
        begin
            out_stall <= 1'b0;
            out_hold = pick_gap(out_calm);
        end
    end

    // Monitor: sample both channels at the rising edge. Predict from each accepted
    // byte, then check each accepted result against the oldest pending frame.
    always @(posedge clk)
    begin
        frame_t done;
        frame_t got;
        frame_t want;
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            bytes_taken++;
            if (parse_byte(rx_byte, done))
                frame_q = {frame_q, done};
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {ch2_strength, ch2_power, ch2_value, ch2_average,
                   ch1_strength, ch1_power, ch1_value, ch1_average};
            frames_seen++;
            if (frame_q.size() == 0)
            begin
                $error("unexpected frame result: ch1_average=%0d ch2_strength=%0d",
                       ch1_average, ch2_strength);
                errors++;
            end
            else
            begin
                want = frame_q.pop_front();
                for (int k = 0; k < NUM_FIELDS; k++)
                    if (got[k] !== want[k])
                    begin
                        $error("%s mismatch: expected %0d, actual %0d",
                               field_name[k], want[k], got[k]);
                        errors++;
                    end
            end
        end
    end

    // End of run: all bytes taken, pending frames drained, then a short settle.
    initial
    begin
        int waited;
        waited = 0;
        wait (rst_n);
        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        while (frame_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (frame_q.size() != 0)
        begin
            $error("%0d frame results never arrived", frame_q.size());
            errors++;
        end
        $display("Parsed %0d stream bytes with random gaps and back-pressure,",
                 bytes_taken);
        $display("checked %0d frame results field by field, %0d errors.",
                 frames_seen, errors);
        if (errors == 0)
            $display("PASS sensor_frame_field_parser_unit");
        else
            $display("FAIL sensor_frame_field_parser_unit");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAIL sensor_frame_field_parser_unit");
        $finish;
    end

endmodule
